/* rtl/dbf_pkg.sv */
package dbf_pkg;

  localparam int unsigned DEPTH_DEF    = 16;
  localparam int unsigned KEY_BITS_DEF = 32;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CAP_W        = 5;
  localparam int unsigned OCC_W        = 5;
  localparam int unsigned STATUS_W     = 3;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ACCEPTED   = 3'd0,
    STAT_OVERLOADED = 3'd1,
    STAT_DUPLICATE  = 3'd2,
    STAT_POPPED     = 3'd3,
    STAT_EMPTY      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SECOND
  } state_e;

  typedef struct packed {
    logic sample;
    logic live;
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

/* rtl/dbf_cell.sv */
module dbf_cell #(
  parameter int unsigned KEY_BITS = dbf_pkg::KEY_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dbf_pkg::cell_ctrl_t        ctrl_i,
  input  logic [KEY_BITS-1:0]        cmp_key_i,
  input  logic [KEY_BITS-1:0]        new_key_i,
  input  logic [dbf_pkg::DATA_W-1:0] new_cid_i,
  input  logic [KEY_BITS-1:0]        nb_key_i,
  input  logic [dbf_pkg::DATA_W-1:0] nb_cid_i,
  input  logic                       seen_i,
  output logic [KEY_BITS-1:0]        key_o,
  output logic [dbf_pkg::DATA_W-1:0] cid_o,
  output logic                       match_o,
  output logic                       seen_o
);

  logic [KEY_BITS-1:0]        key_q, key_d;
  logic [dbf_pkg::DATA_W-1:0] cid_q, cid_d;
  logic                       match_q, match_d;

  always_comb begin
    key_d   = key_q;
    cid_d   = cid_q;
    match_d = match_q;
    if (ctrl_i.sample) begin
      match_d = ctrl_i.live && (key_q == cmp_key_i);
    end
    if (ctrl_i.load) begin
      key_d = new_key_i;
      cid_d = new_cid_i;
    end else if (ctrl_i.shift) begin
      key_d = nb_key_i;
      cid_d = nb_cid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    cid_q <= cid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign key_o   = key_q;
  assign cid_o   = cid_q;
  assign match_o = match_q;
  assign seen_o  = seen_i | match_q;

endmodule

/* rtl/dedup_bounded_fifo.sv */
// Ordered request queue with an occupancy limit and duplicate-key replacement.
// Input channel: an item (kind_i, key_i, call_id_i) transfers at a rising edge
// with start_i high and busy_o low. kind_i 0 pushes, 1 pops the front entry.
// Configuration: cfg_we_i writes cfg_wdata_i into the capacity limit; write
// it only while the block is idle.
// Result channel: out_valid_o marks each result for exactly one cycle; the
// receiver takes it then and cannot stall the block.
// Results: the first result is registered from the EXEC state that follows the
// transfer. A push that evicts a queued entry with the same key gives a second
// result in the next cycle, with last_o high on the final result of the item.
// Item flow: busy_o stays high until the block is through with an item. The
// accepting edge samples the key compare in every cell, the EXEC state shifts
// the cell row and appends, and the SECOND state gives the second result.
// Each queue position is one cell; the row closes up by neighbor transfer.
// Reset: the queue is empty and the limit is 16. Cell contents are not
// cleared; positions past the occupancy are never reported.
module dedup_bounded_fifo #(
  parameter int unsigned DEPTH    = dbf_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BITS = dbf_pkg::KEY_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         kind_i,
  input  logic [dbf_pkg::DATA_W-1:0]   key_i,
  input  logic [dbf_pkg::DATA_W-1:0]   call_id_i,
  input  logic                         cfg_we_i,
  input  logic [dbf_pkg::CAP_W-1:0]    cfg_wdata_i,
  output logic                         out_valid_o,
  output logic [dbf_pkg::STATUS_W-1:0] status_o,
  output logic [dbf_pkg::DATA_W-1:0]   out_key_o,
  output logic [dbf_pkg::DATA_W-1:0]   out_call_id_o,
  output logic [dbf_pkg::OCC_W-1:0]    occupancy_o,
  output logic                         last_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > dbf_pkg::CAP_W) ? CNT_W : dbf_pkg::CAP_W;

  dbf_pkg::state_e state_q, state_d;

  logic [dbf_pkg::CAP_W-1:0]  cap_q;
  logic [CNT_W-1:0]           count_q, count_d;
  logic                       kind_q;
  logic [KEY_BITS-1:0]        key_q;
  logic [dbf_pkg::DATA_W-1:0] cid_q;

  logic                         res_valid_q, res_valid_d;
  logic [dbf_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [dbf_pkg::DATA_W-1:0]   res_key_q, res_key_d;
  logic [dbf_pkg::DATA_W-1:0]   res_cid_q, res_cid_d;
  logic [dbf_pkg::OCC_W-1:0]    res_occ_q, res_occ_d;
  logic                         res_last_q, res_last_d;

  logic                       accept;
  logic [63:0]                key_in_wide;
  logic [KEY_BITS-1:0]        cmp_key;
  logic [63:0]                key_out_wide;
  logic [63:0]                front_key_wide;

  logic [KEY_BITS-1:0]        ck [DEPTH+1];
  logic [dbf_pkg::DATA_W-1:0] cc [DEPTH+1];
  logic                       seen [DEPTH+1];
  logic [DEPTH-1:0]           match;
  dbf_pkg::cell_ctrl_t        ctrl [DEPTH];

  logic                       found;
  logic [dbf_pkg::DATA_W-1:0] ev_cid;
  logic [CMP_W-1:0]           lim;
  logic                       overload;
  logic                       do_pop;
  logic                       do_push;
  logic [CNT_W-1:0]           wr_idx;

  assign accept       = start_i && !busy_o;
  assign key_in_wide  = 64'(key_i);
  assign cmp_key      = key_in_wide[KEY_BITS-1:0];
  assign key_out_wide = 64'(key_q);
  assign front_key_wide = 64'(ck[0]);

  assign ck[DEPTH]   = '0;
  assign cc[DEPTH]   = '0;
  assign seen[0]     = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    dbf_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl[g]),
      .cmp_key_i (cmp_key),
      .new_key_i (key_q),
      .new_cid_i (cid_q),
      .nb_key_i  (ck[g+1]),
      .nb_cid_i  (cc[g+1]),
      .seen_i    (seen[g]),
      .key_o     (ck[g]),
      .cid_o     (cc[g]),
      .match_o   (match[g]),
      .seen_o    (seen[g+1])
    );
  end

  always_comb begin
    ev_cid = '0;
    for (int i = 0; i < DEPTH; i++) begin
      ev_cid = ev_cid | (match[i] ? cc[i] : '0);
    end
  end

  assign found    = seen[DEPTH];
  assign lim      = (CMP_W'(cap_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_q);
  assign overload = (kind_q == dbf_pkg::KIND_PUSH) && (CMP_W'(count_q) >= lim);
  assign do_pop   = (state_q == dbf_pkg::ST_EXEC) && (kind_q == dbf_pkg::KIND_POP) &&
                    (count_q != '0);
  assign do_push  = (state_q == dbf_pkg::ST_EXEC) && (kind_q == dbf_pkg::KIND_PUSH) &&
                    !overload;
  assign wr_idx   = found ? (count_q - CNT_W'(1)) : count_q;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].sample = accept;
      ctrl[i].live   = CNT_W'(i) < count_q;
      ctrl[i].shift  = do_pop || (do_push && seen[i+1]);
      ctrl[i].load   = do_push && (CNT_W'(i) == wr_idx);
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_pop) begin
      count_d = count_q - CNT_W'(1);
    end else if (do_push && !found) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dbf_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = dbf_pkg::ST_EXEC;
        end
      end
      dbf_pkg::ST_EXEC: begin
        state_d = do_push && found ? dbf_pkg::ST_SECOND : dbf_pkg::ST_IDLE;
      end
      dbf_pkg::ST_SECOND: begin
        state_d = dbf_pkg::ST_IDLE;
      end
      default: begin
        state_d = dbf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_o       = 1'b1;
    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_cid_d    = res_cid_q;
    res_occ_d    = res_occ_q;
    res_last_d   = res_last_q;
    unique case (state_q)
      dbf_pkg::ST_IDLE: begin
        busy_o = 1'b0;
      end
      dbf_pkg::ST_EXEC: begin
        res_valid_d = 1'b1;
        res_occ_d   = dbf_pkg::OCC_W'(count_d);
        res_last_d  = 1'b1;
        if (kind_q == dbf_pkg::KIND_POP) begin
          if (count_q == '0) begin
            res_status_d = dbf_pkg::STAT_EMPTY;
            res_key_d    = '0;
            res_cid_d    = '0;
          end else begin
            res_status_d = dbf_pkg::STAT_POPPED;
            res_key_d    = front_key_wide[dbf_pkg::DATA_W-1:0];
            res_cid_d    = cc[0];
          end
        end else if (overload) begin
          res_status_d = dbf_pkg::STAT_OVERLOADED;
          res_key_d    = key_out_wide[dbf_pkg::DATA_W-1:0];
          res_cid_d    = cid_q;
        end else if (found) begin
          res_status_d = dbf_pkg::STAT_DUPLICATE;
          res_key_d    = key_out_wide[dbf_pkg::DATA_W-1:0];
          res_cid_d    = ev_cid;
          res_last_d   = 1'b0;
        end else begin
          res_status_d = dbf_pkg::STAT_ACCEPTED;
          res_key_d    = key_out_wide[dbf_pkg::DATA_W-1:0];
          res_cid_d    = cid_q;
        end
      end
      dbf_pkg::ST_SECOND: begin
        res_valid_d  = 1'b1;
        res_status_d = dbf_pkg::STAT_ACCEPTED;
        res_key_d    = key_out_wide[dbf_pkg::DATA_W-1:0];
        res_cid_d    = cid_q;
        res_occ_d    = dbf_pkg::OCC_W'(count_q);
        res_last_d   = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dbf_pkg::ST_IDLE;
      count_q     <= '0;
      cap_q       <= dbf_pkg::CAP_RESET;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      key_q  <= cmp_key;
      cid_q  <= call_id_i;
    end
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_cid_q    <= res_cid_d;
    res_occ_q    <= res_occ_d;
    res_last_q   <= res_last_d;
  end

  assign out_valid_o   = res_valid_q;
  assign status_o      = res_status_q;
  assign out_key_o     = res_key_q;
  assign out_call_id_o = res_cid_q;
  assign occupancy_o   = res_occ_q;
  assign last_o        = res_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("more than one queued entry matches the key");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == dbf_pkg::ST_EXEC)
    else $error("transfer did not start execution");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(state_q == dbf_pkg::ST_EXEC || state_q == dbf_pkg::ST_SECOND))
    else $error("result strobe without execution");

  a_second_after_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dbf_pkg::ST_SECOND |-> res_valid_q && !res_last_q &&
      res_status_q == dbf_pkg::STAT_DUPLICATE)
    else $error("second result without a duplicate eviction");

endmodule

/* bench/dbf_checker.sv */
`timescale 1ns / 1ps
module dbf_checker #(
  parameter int unsigned DEPTH = dbf_pkg::DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic                         kind_i,
  input  logic [dbf_pkg::DATA_W-1:0]   key_i,
  input  logic [dbf_pkg::DATA_W-1:0]   call_id_i,
  input  logic                         cfg_we_i,
  input  logic [dbf_pkg::CAP_W-1:0]    cfg_wdata_i,
  input  logic                         out_valid_i,
  input  logic [dbf_pkg::STATUS_W-1:0] status_i,
  input  logic [dbf_pkg::DATA_W-1:0]   out_key_i,
  input  logic [dbf_pkg::DATA_W-1:0]   out_call_id_i,
  input  logic [dbf_pkg::OCC_W-1:0]    occupancy_i,
  input  logic                         last_i,
  output int unsigned                  errors_o,
  output int unsigned                  outstanding_o,
  output int unsigned                  results_o,
  output int unsigned                  evictions_o
);
  import dbf_pkg::*;

  typedef struct {
    status_e            status;
    logic [DATA_W-1:0]  key;
    logic [DATA_W-1:0]  call_id;
    logic [OCC_W-1:0]   occupancy;
    logic               last;
  } queue_report_t;

  queue_report_t     pending_reports[$];
  logic [DATA_W-1:0] slot_keys [DEPTH];
  logic [DATA_W-1:0] slot_ids  [DEPTH];
  int unsigned       slot_count;
  logic [CAP_W-1:0]  cap_limit;
  int unsigned       mismatches;
  int unsigned       results_seen;
  int unsigned       evictions;

  function automatic void post_report(input status_e st, input logic [DATA_W-1:0] key,
                                      input logic [DATA_W-1:0] cid, input logic last);
    queue_report_t r;
    r.status    = st;
    r.key       = key;
    r.call_id   = cid;
    r.occupancy = OCC_W'(slot_count);
    r.last      = last;
    pending_reports.push_back(r);
  endfunction

  function automatic void close_up(input int unsigned pos);
    for (int unsigned i = pos; i + 1 < slot_count; i++) begin
      slot_keys[i] = slot_keys[i + 1];
      slot_ids[i]  = slot_ids[i + 1];
    end
    slot_count--;
  endfunction

  function automatic void predict_item(input kind_e kind, input logic [DATA_W-1:0] key,
                                       input logic [DATA_W-1:0] cid);
    int unsigned       cap;
    int                hit;
    logic [DATA_W-1:0] gone_key;
    logic [DATA_W-1:0] gone_id;
    hit = -1;
    gone_key = '0;
    gone_id = '0;
    cap = (cap_limit < DEPTH) ? cap_limit : DEPTH;
    if (kind == KIND_POP) begin
      if (slot_count == 0) begin
        post_report(STAT_EMPTY, '0, '0, 1'b1);
      end else begin
        gone_key = slot_keys[0];
        gone_id  = slot_ids[0];
        close_up(0);
        post_report(STAT_POPPED, gone_key, gone_id, 1'b1);
      end
    end else if (slot_count >= cap) begin
      post_report(STAT_OVERLOADED, key, cid, 1'b1);
    end else begin
      for (int unsigned i = 0; i < slot_count; i++) begin
        if (hit < 0 && slot_keys[i] == key) hit = i;
      end
      if (hit >= 0) begin
        gone_key = slot_keys[hit];
        gone_id  = slot_ids[hit];
        close_up(hit);
      end
      slot_keys[slot_count] = key;
      slot_ids[slot_count]  = cid;
      slot_count++;
      if (hit >= 0) begin
        evictions++;
        post_report(STAT_DUPLICATE, gone_key, gone_id, 1'b0);
      end
      post_report(STAT_ACCEPTED, key, cid, 1'b1);
    end
  endfunction

  function automatic void check_report();
    queue_report_t want;
    bit            bad;
    string         what;
    bad = 1'b0;
    results_seen++;
    if (pending_reports.size() == 0) begin
      bad = 1'b1;
      what = $sformatf("unexpected result: status %0d key %h id %h occ %0d last %0b",
                       status_i, out_key_i, out_call_id_i, occupancy_i, last_i);
    end else begin
      want = pending_reports.pop_front();
      if (status_i !== want.status || out_key_i !== want.key ||
          out_call_id_i !== want.call_id || occupancy_i !== want.occupancy ||
          last_i !== want.last) begin
        bad = 1'b1;
        what = $sformatf({"expected status %0d key %h id %h occ %0d last %0b, ",
                          "got status %0d key %h id %h occ %0d last %0b"},
                         want.status, want.key, want.call_id, want.occupancy, want.last,
                         status_i, out_key_i, out_call_id_i, occupancy_i, last_i);
      end
    end
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) $display("[%0t] result mismatch: %s", $time, what);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_reports.delete();
      slot_count   = 0;
      cap_limit    = CAP_RESET;
      mismatches   = 0;
      results_seen = 0;
      evictions    = 0;
    end else begin
      if (out_valid_i) check_report();
      if (cfg_we_i) cap_limit = cfg_wdata_i;
      if (start_i && !busy_i) predict_item(kind_e'(kind_i), key_i, call_id_i);
    end
    errors_o      = mismatches;
    outstanding_o = pending_reports.size();
    results_o     = results_seen;
    evictions_o   = evictions;
  end

endmodule

/* bench/dedup_bounded_fifo_test.sv */
`timescale 1ns / 1ps
module dedup_bounded_fifo_test;
  import dbf_pkg::*;

  localparam int unsigned PHASES = 10;
  localparam int unsigned PHASE_LIMIT [PHASES] = '{16, 31, 1, 0, 2, 17, 8, 16, 5, 15};
  localparam int unsigned PHASE_ITEMS [PHASES] = '{160, 160, 160, 60, 160, 160, 160, 160,
                                                   160, 160};
  localparam int unsigned PHASE_PUSH  [PHASES] = '{75, 60, 50, 70, 55, 80, 60, 40, 60, 65};

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  logic                  kind_i      = KIND_PUSH;
  logic [DATA_W-1:0]     key_i       = '0;
  logic [DATA_W-1:0]     call_id_i   = '0;
  logic                  cfg_we_i    = 1'b0;
  logic [CAP_W-1:0]      cfg_wdata_i = CAP_RESET;
  logic                  busy_o;
  logic                  out_valid_o;
  logic [STATUS_W-1:0]   status_o;
  logic [DATA_W-1:0]     out_key_o;
  logic [DATA_W-1:0]     out_call_id_o;
  logic [OCC_W-1:0]      occupancy_o;
  logic                  last_o;

  int unsigned errors;
  int unsigned outstanding;
  int unsigned results;
  int unsigned evictions;
  int unsigned transfers_sent;
  int unsigned limit_writes;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  dedup_bounded_fifo u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .kind_i        (kind_i),
    .key_i         (key_i),
    .call_id_i     (call_id_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .out_key_o     (out_key_o),
    .out_call_id_o (out_call_id_o),
    .occupancy_o   (occupancy_o),
    .last_o        (last_o)
  );

  dbf_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .kind_i        (kind_i),
    .key_i         (key_i),
    .call_id_i     (call_id_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_i   (out_valid_o),
    .status_i      (status_o),
    .out_key_i     (out_key_o),
    .out_call_id_i (out_call_id_o),
    .occupancy_i   (occupancy_o),
    .last_i        (last_o),
    .errors_o      (errors),
    .outstanding_o (outstanding),
    .results_o     (results),
    .evictions_o   (evictions)
  );

  // Call at a falling edge; returns at the falling edge after the transfer.
  task automatic transfer(input kind_e kind, input logic [DATA_W-1:0] key,
                          input logic [DATA_W-1:0] cid);
    kind_i    = kind;
    key_i     = key;
    call_id_i = cid;
    start_i   = 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    transfers_sent++;
  endtask

  task automatic hold_off(input int unsigned cycles);
    start_i = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic set_limit(input logic [CAP_W-1:0] value);
    start_i = 1'b0;
    while (outstanding != 0 || busy_o) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    limit_writes++;
  endtask

  task automatic random_phase(input int unsigned count, input int unsigned push_pct);
    logic [DATA_W-1:0] pool [16];
    int unsigned       pool_n;
    int unsigned       burst;
    kind_e             kind;
    logic [DATA_W-1:0] key;
    pool_n = $urandom_range(2, 16);
    for (int j = 0; j < 16; j++) pool[j] = $urandom;
    while (count > 0) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && count > 0) begin
        kind = ($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_POP;
        key  = ($urandom_range(9) < 7) ? pool[$urandom_range(pool_n - 1)] : $urandom;
        transfer(kind, key, $urandom);
        burst--;
        count--;
      end
      if ($urandom_range(2) != 0) hold_off($urandom_range(1, 8));
    end
  endtask

  initial begin
    int unsigned drain_wait;
    transfers_sent = 0;
    limit_writes   = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    transfer(KIND_POP, '1, '1);
    transfer(KIND_PUSH, '0, '0);
    transfer(KIND_PUSH, '1, '1);
    transfer(KIND_PUSH, 32'd5, 32'h1);
    transfer(KIND_PUSH, '0, 32'h2);
    transfer(KIND_PUSH, 32'd5, 32'h3);
    transfer(KIND_PUSH, 32'd5, 32'h4);
    for (int j = 0; j < 13; j++) transfer(KIND_PUSH, 32'h100 + j, 32'hA5A5_0000 + j);
    transfer(KIND_PUSH, 32'd5, 32'h5);
    transfer(KIND_POP, '0, '0);
    set_limit(5'd2);
    transfer(KIND_PUSH, 32'd7, 32'h7);
    set_limit('0);
    transfer(KIND_PUSH, 32'd8, 32'h8);
    set_limit(5'd31);
    transfer(KIND_PUSH, 32'd9, 32'h9);
    transfer(KIND_PUSH, 32'd10, 32'hA);

    for (int p = 0; p < PHASES; p++) begin
      set_limit(CAP_W'(PHASE_LIMIT[p]));
      random_phase(PHASE_ITEMS[p], PHASE_PUSH[p]);
    end

    hold_off(0);
    drain_wait = 0;
    while (outstanding != 0 && drain_wait < 1000) begin
      @(negedge clk_i);
      drain_wait++;
    end
    repeat (8) @(negedge clk_i);

    $display("Covered %0d transfers under %0d capacity limit settings (0, 31 and 16 among them).",
             transfers_sent, limit_writes);
    $display("Checked %0d results including %0d duplicate evictions; %0d left unanswered.",
             results, evictions, outstanding);
    if (errors == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
rtl/dbf_pkg.sv
rtl/dbf_cell.sv
rtl/dedup_bounded_fifo.sv
bench/dbf_checker.sv
bench/dedup_bounded_fifo_test.sv
